[design/grid_raycast_column_shader_core_defines.svh]
// Assertion macros for the grid raycast column shader.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef GRID_RAYCAST_COLUMN_SHADER_CORE_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_SHADER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grc: next-cycle check failed");

`endif

[design/grc_pkg.sv]
// Shared constants, types and the sine table builder for the raycaster.
// No dependencies; imported by every module of the block.
package grc_pkg;

  localparam int DEF_SCREEN_COLUMNS = 120;
  localparam int DEF_SCREEN_ROWS    = 40;
  localparam int DEF_MAP_SIDE       = 16;
  localparam int DEF_MAX_DEPTH      = 16;

  localparam int FOV_UNITS = 512;
  localparam int ONE_Q14   = 16384;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic [7:0] GLYPH_BLANK  = 8'd32;
  localparam logic [7:0] GLYPH_HASH   = 8'd35;
  localparam logic [7:0] GLYPH_X      = 8'd120;
  localparam logic [7:0] GLYPH_DOT    = 8'd46;
  localparam logic [7:0] GLYPH_DASH   = 8'd45;
  localparam logic [7:0] GLYPH_WALL_0 = 8'd219;
  localparam logic [7:0] GLYPH_WALL_1 = 8'd178;
  localparam logic [7:0] GLYPH_WALL_2 = 8'd177;
  localparam logic [7:0] GLYPH_WALL_3 = 8'd176;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  typedef logic [14:0] sin_tab_t [0:1024];

  // Command handed from the front to the back.
  typedef struct packed {
    logic               is_render;
    logic [7:0]         cell_index;
    logic               cell_is_wall;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] eye_x;
    logic signed [15:0] eye_y;
  } grc_cmd_t;

  // Restoring division, used only while building constant tables.
  function automatic longint unsigned const_udiv(input longint unsigned n,
                                                 input longint unsigned dv);
    longint unsigned quo;
    longint unsigned part;
    quo  = 64'd0;
    part = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[62:0], n[b]};
      if (part >= dv) begin
        part   = part - dv;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine in Q14 from a Taylor series in Q2.30.
  function automatic logic [14:0] quarter_sine(input int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    x    = (64'(q) * PI_Q30) >> 11;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 8; k++) begin
      term = const_udiv((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd32768) >> 16;
    return (r > 64'(ONE_Q14)) ? 15'(ONE_Q14) : 15'(r);
  endfunction

  function automatic sin_tab_t build_sine_tab();
    sin_tab_t t;
    for (int i = 0; i <= 1024; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  // Table index for a 12-bit angle; the second quadrant mirrors the first.
  function automatic logic [10:0] sine_index(input logic [11:0] a);
    return a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
  endfunction

endpackage

[design/grid_raycast_column_shader_core.sv]
// Grid raycast column shader: for each render transaction, marches one ray
// through a MAP_SIDE x MAP_SIDE wall map and emits SCREEN_ROWS glyphs.
// Input side is a queue: a transaction is taken when push is high and full low.
// req_type 0 writes one map cell and produces no result; 1 renders a column.
// Result side is a queue: row/glyph/last_row are valid while empty is low and
// leave on pop. Rows come top to bottom, last_row marks the final one.
// A render passes the front end (angle and two sine table reads) and the command
// queue to the march stage, which makes up to MAX_DEPTH march steps, each a STEP
// and a CHECK state (a step that leaves the map ends after STEP), then hands the
// distance to the emitter, which fills the output register row by row.
// Marching of the next column overlaps emission of the current one, so the
// sustained rate is set by the row emitter.
// Map writes pass through the command queue.
// Reset clears all control state; the wall map is not cleared and every cell
// must be written before a ray reaches it. When pop stays low the output
// register holds, the emitter pauses, and full rises once the queue and the
// march stage are occupied.
`include "grid_raycast_column_shader_core_defines.svh"
module grid_raycast_column_shader_core import grc_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int MAP_SIDE       = DEF_MAP_SIDE,
  parameter int MAX_DEPTH      = DEF_MAX_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  cell_index_i,
  input  logic        cell_is_wall_i,
  input  logic [6:0]  column_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [11:0] view_angle_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  row_o,
  output logic [7:0]  glyph_o,
  output logic        last_row_o
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  grc_cmd_t      f_cmd, q_cmd;
  logic          f_push, q_full, q_empty, q_pop;
  logic          d_valid, d_ack;
  logic [DW-1:0] d;

  grc_front #(.SCREEN_COLUMNS(SCREEN_COLUMNS)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .req_type_i, .cell_index_i, .cell_is_wall_i, .column_i,
    .pos_x_i, .pos_y_i, .view_angle_i,
    .q_push_o(f_push), .q_cmd_o(f_cmd), .q_full_i(q_full)
  );

  grc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push), .data_i(f_cmd), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_cmd), .empty_o(q_empty)
  );

  grc_march #(.MAP_SIDE(MAP_SIDE), .MAX_DEPTH(MAX_DEPTH)) u_march (
    .clk_i, .rst_ni,
    .cmd_i(q_cmd), .cmd_empty_i(q_empty), .cmd_pop_o(q_pop),
    .d_valid_o(d_valid), .d_o(d), .d_ack_i(d_ack)
  );

  grc_emit #(.SCREEN_ROWS(SCREEN_ROWS), .MAX_DEPTH(MAX_DEPTH)) u_emit (
    .clk_i, .rst_ni,
    .d_valid_i(d_valid), .d_i(d), .d_ack_o(d_ack),
    .empty, .pop, .row_o, .glyph_o, .last_row_o
  );

  `GRC_ASSERT_IMP(a_last_row, !empty && last_row_o, row_o == 6'(SCREEN_ROWS - 1))
  `GRC_ASSERT_IMP(a_dist_range, d_valid, d >= DW'(1) && d <= DW'(MAX_DEPTH))
  `GRC_ASSERT_NXT(a_dist_hold, d_valid && !d_ack, d_valid && $stable(d))

endmodule

[design/grc_front.sv]
// Front end: accepts items, passes map writes on, and turns render items
// into a ray direction from the sine table. Depends on grc_pkg.
module grc_front import grc_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  cell_index_i,
  input  logic        cell_is_wall_i,
  input  logic [6:0]  column_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [11:0] view_angle_i,
  output logic        q_push_o,
  output grc_cmd_t    q_cmd_o,
  input  logic        q_full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SINX = 2'd1;
  localparam logic [1:0] F_SINY = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  typedef logic [11:0] ofs_tab_t [0:127];

  function automatic ofs_tab_t build_ofs_tab();
    ofs_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 12'(const_udiv(64'(i * FOV_UNITS), 64'(SCREEN_COLUMNS)));
    end
    return t;
  endfunction

  localparam ofs_tab_t OfsTab = build_ofs_tab();
  localparam sin_tab_t SinTab = build_sine_tab();

  logic [1:0]         state_q, state_d;
  logic [11:0]        ang_q;
  logic               neg_q;
  logic [15:0]        px_q, py_q;
  logic signed [15:0] ex_q, ey_q;
  logic [14:0]        rom_q;
  logic [10:0]        rom_idx;
  logic [11:0]        new_ang;
  logic [11:0]        ang_y;
  logic               accept;
  logic signed [15:0] rom_val;

  assign full    = (state_q != F_IDLE) || q_full_i;
  assign accept  = push && !full;
  assign new_ang = view_angle_i - 12'(FOV_UNITS / 2) + OfsTab[column_i];
  assign ang_y   = ang_q + 12'd1024;
  assign rom_idx = (state_q == F_IDLE) ? sine_index(new_ang) : sine_index(ang_y);
  assign rom_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk_i) begin
    rom_q <= SinTab[rom_idx];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && req_type_i == REQ_RENDER) state_d = F_SINX;
      end
      F_SINX: state_d = F_SINY;
      F_SINY: state_d = F_PUSH;
      F_PUSH: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        ang_q <= new_ang;
        neg_q <= new_ang[11];
        px_q  <= pos_x_i;
        py_q  <= pos_y_i;
      end
      F_SINX: begin
        ex_q  <= rom_val;
        neg_q <= ang_y[11];
      end
      F_SINY: ey_q <= rom_val;
      default: ;
    endcase
  end

  always_comb begin
    q_cmd_o = '0;
    if (state_q == F_IDLE) begin
      q_push_o             = accept && req_type_i == REQ_WRITE;
      q_cmd_o.is_render    = REQ_WRITE;
      q_cmd_o.cell_index   = cell_index_i;
      q_cmd_o.cell_is_wall = cell_is_wall_i;
    end else begin
      q_push_o          = (state_q == F_PUSH) && !q_full_i;
      q_cmd_o.is_render = REQ_RENDER;
      q_cmd_o.pos_x     = px_q;
      q_cmd_o.pos_y     = py_q;
      q_cmd_o.eye_x     = ex_q;
      q_cmd_o.eye_y     = ey_q;
    end
  end

endmodule

[design/grc_queue.sv]
// Two-entry command queue between the front and the back.
// Depends on grc_pkg for the command type.
module grc_queue import grc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  grc_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output grc_cmd_t data_o,
  output logic     empty_o
);

  grc_cmd_t   mem_q [0:1];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/grc_march.sv]
// Back end, first half: owns the wall map, applies writes and marches rays.
// Depends on grc_pkg; hands the hit distance to the row emitter.
module grc_march import grc_pkg::*; #(
  parameter int MAP_SIDE  = DEF_MAP_SIDE,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grc_cmd_t      cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic          d_valid_o,
  output logic [DW-1:0] d_o,
  input  logic          d_ack_i
);

  localparam int Cells = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(MAP_SIDE);
  localparam int AccW  = 24;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_STEP  = 2'd1;
  localparam logic [1:0] M_CHECK = 2'd2;
  localparam logic [1:0] M_DONE  = 2'd3;

  localparam logic signed [AccW-1:0] LowLim = AccW'(-ONE_Q14);

  logic [1:0]             state_q;
  logic [DW-1:0]          d_q;
  logic signed [AccW-1:0] ax_q, ay_q, nx, ny;
  logic signed [15:0]     ex_q, ey_q;
  logic                   map_q [0:Cells-1];
  logic                   rd_q;
  logic                   we;
  logic [AW-1:0]          ra;
  logic [CW-1:0]          tx, ty;
  logic                   outside;

  assign cmd_pop_o = (state_q == M_IDLE) && !cmd_empty_i;
  assign we        = cmd_pop_o && !cmd_i.is_render && (32'(cmd_i.cell_index) < Cells);
  assign d_valid_o = state_q == M_DONE;
  assign d_o       = d_q;

  assign nx = ax_q + AccW'(ex_q);
  assign ny = ay_q + AccW'(ey_q);

  function automatic logic coord_out(input logic signed [AccW-1:0] v);
    return (v <= LowLim) ||
           (!v[AccW-1] && ($unsigned(v[AccW-1:14]) >= (AccW-14)'(MAP_SIDE)));
  endfunction

  // Coordinates in (-1,0) truncate toward zero and test cell 0.
  assign tx      = nx[AccW-1] ? '0 : nx[14 +: CW];
  assign ty      = ny[AccW-1] ? '0 : ny[14 +: CW];
  assign outside = coord_out(nx) || coord_out(ny);
  assign ra      = AW'(32'(ty) * MAP_SIDE + 32'(tx));

  always_ff @(posedge clk_i) begin
    if (we) map_q[AW'(cmd_i.cell_index)] <= cmd_i.cell_is_wall;
    rd_q <= map_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (cmd_pop_o && cmd_i.is_render) state_q <= M_STEP;
        end
        M_STEP: state_q <= outside ? M_DONE : M_CHECK;
        M_CHECK: begin
          if (rd_q || d_q == DW'(MAX_DEPTH)) state_q <= M_DONE;
          else state_q <= M_STEP;
        end
        M_DONE: begin
          if (d_ack_i) state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        ax_q <= AccW'({cmd_i.pos_x, 2'b00});
        ay_q <= AccW'({cmd_i.pos_y, 2'b00});
        ex_q <= cmd_i.eye_x;
        ey_q <= cmd_i.eye_y;
        d_q  <= '0;
      end
      M_STEP: begin
        ax_q <= nx;
        ay_q <= ny;
        d_q  <= outside ? DW'(MAX_DEPTH) : d_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[design/grc_emit.sv]
// Back end, second half: turns a hit distance into one glyph per screen row.
// Depends on grc_pkg; drives the result queue ports through a register.
module grc_emit import grc_pkg::*; #(
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
  parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          d_valid_i,
  input  logic [DW-1:0] d_i,
  output logic          d_ack_o,
  output logic          empty,
  input  logic          pop,
  output logic [5:0]    row_o,
  output logic [7:0]    glyph_o,
  output logic          last_row_o
);

  localparam int YW = $clog2(SCREEN_ROWS);

  logic               busy_q, out_v_q, last_q;
  logic [YW-1:0]      y_q;
  logic [DW-1:0]      dist_q;
  logic [5:0]         row_q;
  logic [7:0]         glyph_q, wall_g, floor_g, g;
  logic               slot_free, is_last;
  logic signed [15:0] num, den, ydn, top, dd, yy, rem;

  assign empty      = !out_v_q;
  assign row_o      = row_q;
  assign glyph_o    = glyph_q;
  assign last_row_o = last_q;
  assign slot_free  = !out_v_q || pop;
  assign d_ack_o    = !busy_q && d_valid_i;
  assign is_last    = y_q == YW'(SCREEN_ROWS - 1);

  // Blank while y*2d <= R*(d-2); wall while R*(d-2) < (R-y+1)*2d.
  assign dd  = signed'(16'(dist_q));
  assign yy  = signed'(16'(y_q));
  assign num = 16'(SCREEN_ROWS) * (dd - 16'sd2);
  assign den = dd <<< 1;
  assign ydn = yy * den;
  assign top = (16'(SCREEN_ROWS) - yy + 16'sd1) * den;
  assign rem = 16'(SCREEN_ROWS) - yy;

  always_comb begin
    if (4 * dd <= 16'(MAX_DEPTH)) wall_g = GLYPH_WALL_0;
    else if (3 * dd < 16'(MAX_DEPTH)) wall_g = GLYPH_WALL_1;
    else if (2 * dd < 16'(MAX_DEPTH)) wall_g = GLYPH_WALL_2;
    else if (dd < 16'(MAX_DEPTH)) wall_g = GLYPH_WALL_3;
    else wall_g = GLYPH_BLANK;

    if (8 * rem < 16'(SCREEN_ROWS)) floor_g = GLYPH_HASH;
    else if (4 * rem < 16'(SCREEN_ROWS)) floor_g = GLYPH_X;
    else if (8 * rem < 16'(3 * SCREEN_ROWS)) floor_g = GLYPH_DOT;
    else if (20 * rem < 16'(9 * SCREEN_ROWS)) floor_g = GLYPH_DASH;
    else floor_g = GLYPH_BLANK;

    if (ydn <= num) g = GLYPH_BLANK;
    else if (num < top) g = wall_g;
    else g = floor_g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
      y_q     <= '0;
    end else begin
      if (d_ack_o) begin
        busy_q <= 1'b1;
        y_q    <= '0;
      end else if (busy_q && slot_free) begin
        y_q <= y_q + 1'b1;
        if (is_last) busy_q <= 1'b0;
      end
      if (busy_q && slot_free) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ack_o) dist_q <= d_i;
    if (busy_q && slot_free) begin
      row_q   <= 6'(y_q);
      glyph_q <= g;
      last_q  <= is_last;
    end
  end

endmodule

[dv/grid_raycast_column_shader_core_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the grid raycast column shader: mirrors the wall map, predicts the
// glyph column of every accepted render and compares each popped row in order.
// Depends on grc_pkg for the glyph codes and the request type codes.
module grid_raycast_column_shader_core_checker import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        req_type_i,
  input  logic [7:0]  cell_index_i,
  input  logic        cell_is_wall_i,
  input  logic [6:0]  column_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [11:0] view_angle_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [5:0]  row_o,
  input  logic [7:0]  glyph_o,
  input  logic        last_row_o,
  output int          mismatch_count,
  output int          rows_pending
);

  localparam int ROWS  = 40;
  localparam int SIDE  = 16;
  localparam int DEPTH = 16;

  typedef struct packed {
    logic [5:0] row;
    logic [7:0] glyph;
    logic       last_row;
  } shade_row_t;

  shade_row_t  shade_rows_q[$];
  bit          wall_cells[SIDE*SIDE];
  int unsigned quarter_wave[0:1024];
  int          errors = 0;

  assign mismatch_count = errors;

  // Taylor series in unsigned Q2.30, truncating at each step, rounded to Q14.
  function automatic int unsigned taylor_q14(int unsigned q);
    longint unsigned x, x2, term, acc, r;
    x    = (64'(q) * 64'd3373259426) >> 11;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = (term > acc) ? 64'd0 : acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r = (acc + 64'd32768) >> 16;
    return (r > 64'd16384) ? 16384 : int'(r);
  endfunction

  function automatic longint signed_sine(logic [11:0] a);
    int unsigned mag;
    mag = a[10] ? quarter_wave[1024 - int'(a[9:0])] : quarter_wave[int'(a[9:0])];
    return a[11] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint cell_of(longint v);
    return (v >= 0) ? (v >>> 14) : -((-v) >>> 14);
  endfunction

  function automatic logic [7:0] ground_char(int y);
    int rem;
    rem = ROWS - y;
    if (8 * rem < ROWS) return GLYPH_HASH;
    if (4 * rem < ROWS) return GLYPH_X;
    if (8 * rem < 3 * ROWS) return GLYPH_DOT;
    if (20 * rem < 9 * ROWS) return GLYPH_DASH;
    return GLYPH_BLANK;
  endfunction

  task automatic predict_column(logic [6:0] col, logic [15:0] px_in, logic [15:0] py_in,
                                logic [11:0] facing);
    logic [11:0] ray;
    longint      px, py, ex, ey, tx, ty;
    int          steps, ceil_row, floor_row;
    logic [7:0]  wall_char, g;
    shade_row_t  s;
    ray   = facing - 12'd256 + 12'((int'(col) * 512) / 120);
    ex    = signed_sine(ray);
    ey    = signed_sine(ray + 12'd1024);
    px    = longint'(px_in) * 4;
    py    = longint'(py_in) * 4;
    steps = 0;
    while (steps < DEPTH) begin
      steps++;
      tx = cell_of(px + ex * steps);
      ty = cell_of(py + ey * steps);
      if (tx < 0 || tx >= SIDE || ty < 0 || ty >= SIDE) begin
        steps = DEPTH;
        break;
      end
      if (wall_cells[ty * SIDE + tx]) break;
    end
    ceil_row  = (ROWS * (steps - 2)) / (2 * steps);
    floor_row = ROWS - ceil_row;
    if (4 * steps <= DEPTH) wall_char = GLYPH_WALL_0;
    else if (3 * steps < DEPTH) wall_char = GLYPH_WALL_1;
    else if (2 * steps < DEPTH) wall_char = GLYPH_WALL_2;
    else if (steps < DEPTH) wall_char = GLYPH_WALL_3;
    else wall_char = GLYPH_BLANK;
    for (int y = 0; y < ROWS; y++) begin
      if (y <= ceil_row) g = GLYPH_BLANK;
      else if (y <= floor_row) g = wall_char;
      else g = ground_char(y);
      s.row      = 6'(y);
      s.glyph    = g;
      s.last_row = (y == ROWS - 1);
      shade_rows_q.push_back(s);
    end
  endtask

  initial begin
    for (int i = 0; i <= 1024; i++) quarter_wave[i] = taylor_q14(i);
  end

  always @(posedge clk_i) begin
    shade_row_t want;
    if (rst_ni && push && !full) begin
      if (req_type_i == REQ_WRITE) begin
        wall_cells[cell_index_i] = cell_is_wall_i;
      end else begin
        predict_column(column_i, pos_x_i, pos_y_i, view_angle_i);
      end
    end
    if (rst_ni && pop && !empty) begin
      if (shade_rows_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: expected no row, got row %0d glyph %0d last %0b", $time, row_o,
                   glyph_o, last_row_o);
      end else begin
        want = shade_rows_q.pop_front();
        if (want.row !== row_o || want.glyph !== glyph_o || want.last_row !== last_row_o) begin
          errors++;
          if (errors <= 10)
            $display("%0t: expected row %0d glyph %0d last %0b, got row %0d glyph %0d last %0b",
                     $time, want.row, want.glyph, want.last_row, row_o, glyph_o, last_row_o);
        end
      end
    end
    rows_pending = shade_rows_q.size();
  end

endmodule

[dv/tb_grid_raycast_column_shader_core.sv]
`timescale 1ns / 1ps
// Top of the raycast column shader testbench: clock, reset, map loading, render
// stimulus and result draining; the checker module does all the comparing.
module tb_grid_raycast_column_shader_core import grc_pkg::*;;

  localparam int RANDOM_ITEMS = 180;
  localparam int CYCLE_LIMIT  = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push = 1'b0;
  logic        full;
  logic        req_type_i = REQ_WRITE;
  logic [7:0]  cell_index_i = '0;
  logic        cell_is_wall_i = 1'b0;
  logic [6:0]  column_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [11:0] view_angle_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  row_o;
  logic [7:0]  glyph_o;
  logic        last_row_o;
  int          mismatch_count;
  int          rows_pending;
  int          cycle_count = 0;
  int          renders_sent = 0;
  bit          quiet_phase = 1'b0;

  grid_raycast_column_shader_core u_top (.*);
  grid_raycast_column_shader_core_checker u_checker (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic kind, logic [7:0] cell_idx, logic wall, logic [6:0] col,
                              logic [15:0] px, logic [15:0] py, logic [11:0] facing);
    @(negedge clk_i);
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_type_i     <= kind;
    cell_index_i   <= cell_idx;
    cell_is_wall_i <= wall;
    column_i       <= col;
    pos_x_i        <= px;
    pos_y_i        <= py;
    view_angle_i   <= facing;
    push           <= 1'b1;
    do @(posedge clk_i); while (full);
    if (kind == REQ_RENDER) renders_sent++;
  endtask

  task automatic render_random();
    send_request(REQ_RENDER, 8'($urandom), 1'($urandom),
                 ($urandom_range(0, 19) == 0) ? 7'($urandom_range(120, 127))
                                              : 7'($urandom_range(0, 119)),
                 16'($urandom), 16'($urandom), 12'($urandom));
  endtask

  // Result side: random pop bursts, one long hold-off to back the block up.
  initial begin
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && renders_sent >= 12) begin
        pop <= 1'b0;
        repeat (600) @(negedge clk_i);
        held_off = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    // Assert reset through an edge so the asynchronous reset takes effect.
    rst_ni <= 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every cell is written before any ray can reach it: a mostly walled border, sparse inside.
    for (int i = 0; i < 256; i++) begin
      send_request(REQ_WRITE, 8'(i),
                   (i < 16 || i >= 240 || i % 16 == 0 || i % 16 == 15) ?
                   1'($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 4) == 0),
                   7'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
    end

    // Directed: field extremes, column past the screen, a wall right beside the player.
    send_request(REQ_RENDER, 8'hFF, 1'b1, 7'd0, 16'h0000, 16'h0000, 12'd0);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd119, 16'hFFFF, 16'hFFFF, 12'd4095);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd127, 16'h8000, 16'h8000, 12'd2048);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd60, 16'h8000, 16'h8000, 12'd1024);
    send_request(REQ_WRITE, 8'h88, 1'b0, 7'd0, 16'h0, 16'h0, 12'd0);
    send_request(REQ_WRITE, 8'h89, 1'b1, 7'd0, 16'h0, 16'h0, 12'd0);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd60, 16'h8800, 16'h8800, 12'd1024);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd60, 16'h8800, 16'h8800, 12'd3072);
    // Open the right border so that rays leave the map.
    for (int r = 0; r < 16; r++)
      send_request(REQ_WRITE, 8'(r * 16 + 15), 1'b0, 7'd0, 16'h0, 16'h0, 12'd0);
    send_request(REQ_RENDER, 8'h00, 1'b0, 7'd64, 16'hF000, 16'h8000, 12'd1024);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - 40) quiet_phase = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        send_request(REQ_WRITE, 8'($urandom), 1'($urandom_range(0, 2) == 0), 7'($urandom),
                     16'($urandom), 16'($urandom), 12'($urandom));
      end else begin
        render_random();
      end
    end
    @(negedge clk_i);
    push <= 1'b0;

    while (rows_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/grc_pkg.sv
design/grc_front.sv
design/grc_queue.sv
design/grc_march.sv
design/grc_emit.sv
design/grid_raycast_column_shader_core.sv
dv/grid_raycast_column_shader_core_checker.sv
dv/tb_grid_raycast_column_shader_core.sv
